// File: rtl/stq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted timer queue package
// Shared types and constants for the timer queue cell chain and its top level.
// ----------------------------------------------------------------------------
package stq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int TIME_W      = 32;
	localparam int HANDLE_W    = 16;
	localparam int EVENT_W     = 8;
	localparam int STEP_W      = 16;
	localparam int KIND_W      = 2;

	localparam logic [STEP_W-1:0] TICK_STEP_RESET = STEP_W'(10);

	localparam logic [KIND_W-1:0] KIND_ACCEPTED = 2'd0;
	localparam logic [KIND_W-1:0] KIND_REJECTED = 2'd1;
	localparam logic [KIND_W-1:0] KIND_FIRED    = 2'd2;

	localparam logic MODE_TICK     = 1'b0;
	localparam logic MODE_SCHEDULE = 1'b1;

	typedef struct packed {
		logic [TIME_W-1:0]   deadline;
		logic [HANDLE_W-1:0] handle;
		logic [EVENT_W-1:0]  event_id;
	} entry_t;

	// operation applied to every cell in a cycle
	typedef struct packed {
		logic ins_en;
		logic fire_en;
	} cell_op_t;

	// status a cell reports to the top level and its right neighbour
	typedef struct packed {
		logic valid;
		logic gt;
		logic rm;
		logic first;
		logic later;
	} cell_stat_t;

	typedef enum logic {
		ST_IDLE,
		ST_FIRE
	} fsm_t;

endpackage : stq_pkg
`default_nettype wire

// File: rtl/stq_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Timer queue cell
// Holds one table entry; shifts right on insert and left on removal.
// ----------------------------------------------------------------------------
module stq_cell (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire stq_pkg::cell_op_t             op,
	input  wire logic [stq_pkg::TIME_W-1:0]    cur_time,
	input  wire stq_pkg::entry_t               new_entry,
	input  wire stq_pkg::entry_t               left_entry,
	input  wire logic                          left_valid,
	input  wire logic                          left_gt,
	input  wire logic                          left_rm,
	input  wire stq_pkg::entry_t               right_entry,
	input  wire logic                          right_valid,
	output stq_pkg::entry_t                    entry,
	output stq_pkg::entry_t                    hit_entry,
	output stq_pkg::cell_stat_t                stat
);
	import stq_pkg::*;

	entry_t entry_q;
	logic   valid_q;
	logic   gt;
	logic   match;
	logic   rm;
	logic   take;

	always_comb begin
		gt    = valid_q && (entry_q.deadline > new_entry.deadline);
		match = valid_q && (entry_q.deadline == cur_time);
		rm    = left_rm || match;
		// new entry lands at the first later deadline or the first free slot
		take  = gt || (!valid_q && left_valid);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (op.ins_en && take) begin
			valid_q <= 1'b1;
		end else if (op.fire_en && rm) begin
			valid_q <= right_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (op.ins_en && take) begin
			entry_q <= left_gt ? left_entry : new_entry;
		end else if (op.fire_en && rm) begin
			entry_q <= right_entry;
		end
	end

	always_comb begin
		entry      = entry_q;
		stat.valid = valid_q;
		stat.gt    = gt;
		stat.rm    = rm;
		stat.first = match && !left_rm;
		stat.later = match && left_rm;
		hit_entry  = stat.first ? entry_q : '0;
	end

endmodule : stq_cell
`default_nettype wire

// File: rtl/sorted_timer_callback_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted timer callback queue
// Deadline-ordered callback table held in a chain of cells, with running time.
// ----------------------------------------------------------------------------
// Schedule: result registered in the next cycle; busy stays low, one schedule a cycle while no tick is busy.
// Tick: busy in the FIRE state, entered even when no entry is due; time and state are
//   registered, then the first result, the rest back to back, set by the one-removal-per-cycle shift.
// Results are strobed for one cycle; the receiver cannot stall.
// Reset: time zero, tick_step 10, table empty; no clearing pass.
module sorted_timer_callback_queue (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic                            mode,
	input  wire logic [stq_pkg::TIME_W-1:0]      delay,
	input  wire logic [stq_pkg::HANDLE_W-1:0]    target_handle,
	input  wire logic [stq_pkg::EVENT_W-1:0]     event_id,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [stq_pkg::STEP_W-1:0]      cfg_tick_step,
	output logic                                 strobe,
	output logic [stq_pkg::KIND_W-1:0]           kind,
	output logic [stq_pkg::HANDLE_W-1:0]         fired_handle,
	output logic [stq_pkg::EVENT_W-1:0]          fired_id,
	output logic [stq_pkg::TIME_W-1:0]           deadline,
	output logic                                 last
);
	import stq_pkg::*;

	fsm_t                state_q;
	fsm_t                state_d;
	logic [TIME_W-1:0]   time_q;
	logic [STEP_W-1:0]   step_q;
	logic                accept;
	logic                full;
	logic                any_first;
	logic                any_later;
	cell_op_t            op;
	entry_t              new_entry;
	entry_t              sel_entry;

	entry_t              cell_entry [QUEUE_DEPTH];
	entry_t              cell_hit   [QUEUE_DEPTH];
	cell_stat_t          cell_stat  [QUEUE_DEPTH];

	logic                strobe_q;
	logic [KIND_W-1:0]   kind_q;
	logic [HANDLE_W-1:0] handle_q;
	logic [EVENT_W-1:0]  id_q;
	logic [TIME_W-1:0]   deadline_q;
	logic                last_q;

	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;
	assign full      = cell_stat[QUEUE_DEPTH-1].valid;

	always_comb begin
		new_entry.deadline = time_q + delay;
		new_entry.handle   = target_handle;
		new_entry.event_id = event_id;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && mode == MODE_TICK) state_d = ST_FIRE;
			end
			ST_FIRE: begin
				if (!any_first || !any_later) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the state machine
	always_comb begin
		busy       = 1'b0;
		op.ins_en  = 1'b0;
		op.fire_en = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				op.ins_en = accept && (mode == MODE_SCHEDULE) && !full;
			end
			ST_FIRE: begin
				busy       = 1'b1;
				op.fire_en = any_first;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q <= '0;
			step_q <= TICK_STEP_RESET;
		end else begin
			if (accept && mode == MODE_TICK) begin
				time_q <= time_q + TIME_W'(step_q);
			end
			if (cfg_valid && cfg_ready) begin
				step_q <= cfg_tick_step;
			end
		end
	end

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		entry_t lentry;
		entry_t rentry;
		logic   lvalid;
		logic   lgt;
		logic   lrm;
		logic   rvalid;

		if (i == 0) begin : g_head
			assign lentry = new_entry;
			assign lvalid = 1'b1;
			assign lgt    = 1'b0;
			assign lrm    = 1'b0;
		end else begin : g_body
			assign lentry = cell_entry[i-1];
			assign lvalid = cell_stat[i-1].valid;
			assign lgt    = cell_stat[i-1].gt;
			assign lrm    = cell_stat[i-1].rm;
		end

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign rentry = '0;
			assign rvalid = 1'b0;
		end else begin : g_inner
			assign rentry = cell_entry[i+1];
			assign rvalid = cell_stat[i+1].valid;
		end

		stq_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.op          (op),
			.cur_time    (time_q),
			.new_entry   (new_entry),
			.left_entry  (lentry),
			.left_valid  (lvalid),
			.left_gt     (lgt),
			.left_rm     (lrm),
			.right_entry (rentry),
			.right_valid (rvalid),
			.entry       (cell_entry[i]),
			.hit_entry   (cell_hit[i]),
			.stat        (cell_stat[i])
		);
	end

	// pick the first due entry; flag whether another one follows
	always_comb begin
		sel_entry = '0;
		any_first = 1'b0;
		any_later = 1'b0;
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			sel_entry = sel_entry | cell_hit[i];
			any_first = any_first | cell_stat[i].first;
			any_later = any_later | cell_stat[i].later;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= (accept && mode == MODE_SCHEDULE) || op.fire_en;
		end
	end

	always_ff @(posedge clk) begin
		if (op.fire_en) begin
			kind_q     <= KIND_FIRED;
			handle_q   <= sel_entry.handle;
			id_q       <= sel_entry.event_id;
			deadline_q <= sel_entry.deadline;
			last_q     <= !any_later;
		end else if (accept && mode == MODE_SCHEDULE) begin
			kind_q     <= full ? KIND_REJECTED : KIND_ACCEPTED;
			handle_q   <= target_handle;
			id_q       <= event_id;
			deadline_q <= new_entry.deadline;
			last_q     <= 1'b1;
		end
	end

	assign strobe       = strobe_q;
	assign kind         = kind_q;
	assign fired_handle = handle_q;
	assign fired_id     = id_q;
	assign deadline     = deadline_q;
	assign last         = last_q;

endmodule : sorted_timer_callback_queue
`default_nettype wire
